>>> hdl/dtsm_pkg.sv
// Shared widths and command codes for the delta-time stream merger.
`timescale 1ns / 1ps
package dtsm_pkg;

	localparam int unsigned STREAM_W = 4;
	localparam int unsigned DELTA_W  = 28;
	localparam int unsigned EVENT_W  = 24;
	localparam int unsigned CFG_W    = 5;

	localparam logic [CFG_W-1:0] STREAMS_RESET = 5'd16;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

endpackage

>>> hdl/dtsm_if.sv
// Valid/ready channel interfaces for the command and result streams of the merger.
`timescale 1ns / 1ps
interface dtsm_cmd_if;
	logic                             valid;
	logic                             ready;
	dtsm_pkg::cmd_t                   cmd;
	logic [dtsm_pkg::STREAM_W-1:0]    stream_index;
	logic                             slot_has_event;
	logic [dtsm_pkg::DELTA_W-1:0]     delta_in;
	logic [dtsm_pkg::EVENT_W-1:0]     event_in;

	modport source (output valid, cmd, stream_index, slot_has_event, delta_in, event_in,
		input ready);
	modport sink (input valid, cmd, stream_index, slot_has_event, delta_in, event_in,
		output ready);
endinterface

interface dtsm_res_if;
	logic                             valid;
	logic                             ready;
	logic [dtsm_pkg::STREAM_W-1:0]    out_stream;
	logic [dtsm_pkg::DELTA_W-1:0]     out_delta;
	logic [dtsm_pkg::EVENT_W-1:0]     out_event;
	logic                             end_of_streams;

	modport source (output valid, out_stream, out_delta, out_event, end_of_streams,
		input ready);
	modport sink (input valid, out_stream, out_delta, out_event, end_of_streams,
		output ready);
endinterface

>>> hdl/delta_time_stream_merger.sv
// Top level of the delta-time stream merger: configuration register, slot memories and sequencer.
//
//  Channel  Dir  Handshake              Moves
//  cmd_ch   in   valid/ready            load or read command
//  res_ch   out  valid/ready            merged event or end of streams
//  cfg      in   cfg_wr_en, no wait     streams_in_use
//
// A load writes its slot as it is accepted. A read keeps the input busy while the single read
// port of the delta memory is walked over the streams in use, once for the minimum and once
// for the subtract; a read that finds no valid slot skips the subtract. A finished result sits
// in an output register, so the next command is taken while it waits; a later read stalls in
// S_EMIT until that register is free. Reset clears the valid bits at once; no clearing pass is
// needed.
`timescale 1ns / 1ps
module delta_time_stream_merger #(
	parameter int unsigned SLOTS      = 16,
	parameter int unsigned DELTA_BITS = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dtsm_cmd_if.sink                     cmd_ch,
	dtsm_res_if.source                   res_ch,
	input  logic                         cfg_wr_en,
	input  logic [dtsm_pkg::CFG_W-1:0]   cfg_wr_data
);

	import dtsm_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);

	logic [CFG_W-1:0]      streams_q;
	logic                  d_we;
	logic [IDX_W-1:0]      d_waddr;
	logic [DELTA_BITS-1:0] d_wdata;
	logic                  d_re;
	logic [IDX_W-1:0]      d_raddr;
	logic [DELTA_BITS-1:0] d_rdata;
	logic                  e_we;
	logic [IDX_W-1:0]      e_waddr;
	logic [EVENT_W-1:0]    e_wdata;
	logic                  e_re;
	logic [IDX_W-1:0]      e_raddr;
	logic [EVENT_W-1:0]    e_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streams_q <= STREAMS_RESET;
		end else if (cfg_wr_en) begin
			streams_q <= cfg_wr_data;
		end
	end

	dtsm_ram #(
		.WIDTH (DELTA_BITS),
		.DEPTH (SLOTS)
	) u_delta_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	dtsm_ram #(
		.WIDTH (EVENT_W),
		.DEPTH (SLOTS)
	) u_event_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (e_re),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	dtsm_ctrl #(
		.SLOTS      (SLOTS),
		.DELTA_BITS (DELTA_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_ch         (cmd_ch),
		.res_ch         (res_ch),
		.streams_in_use (streams_q),
		.d_we           (d_we),
		.d_waddr        (d_waddr),
		.d_wdata        (d_wdata),
		.d_re           (d_re),
		.d_raddr        (d_raddr),
		.d_rdata        (d_rdata),
		.e_we           (e_we),
		.e_waddr        (e_waddr),
		.e_wdata        (e_wdata),
		.e_re           (e_re),
		.e_raddr        (e_raddr),
		.e_rdata        (e_rdata)
	);

endmodule

>>> hdl/dtsm_ram.sv
// Simple dual-port synchronous RAM with one registered read port.
`timescale 1ns / 1ps
module dtsm_ram #(
	parameter int unsigned WIDTH = 28,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dtsm_ctrl.sv
// Sequencer that loads slots, runs the minimum search and subtract passes, and holds the result.
`timescale 1ns / 1ps
module dtsm_ctrl #(
	parameter int unsigned SLOTS      = 16,
	parameter int unsigned DELTA_BITS = 28
) (
	input  logic                             clk,
	input  logic                             arst_n,
	dtsm_cmd_if.sink                         cmd_ch,
	dtsm_res_if.source                       res_ch,
	input  logic [dtsm_pkg::CFG_W-1:0]       streams_in_use,
	output logic                             d_we,
	output logic [$clog2(SLOTS)-1:0]         d_waddr,
	output logic [DELTA_BITS-1:0]            d_wdata,
	output logic                             d_re,
	output logic [$clog2(SLOTS)-1:0]         d_raddr,
	input  logic [DELTA_BITS-1:0]            d_rdata,
	output logic                             e_we,
	output logic [$clog2(SLOTS)-1:0]         e_waddr,
	output logic [dtsm_pkg::EVENT_W-1:0]     e_wdata,
	output logic                             e_re,
	output logic [$clog2(SLOTS)-1:0]         e_raddr,
	input  logic [dtsm_pkg::EVENT_W-1:0]     e_rdata
);

	import dtsm_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_SUB  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [SLOTS-1:0]        valid_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        best_q;
	logic [DELTA_BITS-1:0]   dmin_q;
	logic                    found_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;

	logic                    out_valid_q;
	logic [STREAM_W-1:0]     out_stream_q;
	logic [DELTA_W-1:0]      out_delta_q;
	logic [EVENT_W-1:0]      out_event_q;
	logic                    out_eos_q;

	logic                    accept;
	logic                    load_ok;
	logic [IDX_W-1:0]        load_idx;
	logic [CNT_W-1:0]        n_next;
	logic                    walking;
	logic                    issue;
	logic                    pass_done;
	logic                    take;
	logic                    scan_better;
	logic                    sub_wr;
	logic                    out_load;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign load_ok      = accept && (cmd_ch.cmd == CMD_LOAD)
		&& (32'(cmd_ch.stream_index) < 32'(SLOTS));
	assign load_idx     = IDX_W'(cmd_ch.stream_index);
	assign n_next       = (32'(streams_in_use) > 32'(SLOTS)) ? CNT_W'(SLOTS)
		: CNT_W'(streams_in_use);

	assign walking     = (state_q == S_SCAN) || (state_q == S_SUB);
	assign issue       = walking && (ptr_q < n_q);
	assign pass_done   = walking && !issue && !rd_vld_s1;
	assign take        = rd_vld_s1 && valid_q[rd_idx_s1];
	assign scan_better = (state_q == S_SCAN) && take && (!found_q || (d_rdata < dmin_q));
	assign sub_wr      = (state_q == S_SUB) && take && (rd_idx_s1 != best_q);
	assign out_load    = (state_q == S_EMIT) && (!out_valid_q || res_ch.ready);

	always_comb begin
		d_re    = issue;
		d_raddr = ptr_q[IDX_W-1:0];
		d_we    = sub_wr || (load_ok && cmd_ch.slot_has_event);
		d_waddr = (state_q == S_SUB) ? rd_idx_s1 : load_idx;
		d_wdata = (state_q == S_SUB) ? (d_rdata - dmin_q) : DELTA_BITS'(cmd_ch.delta_in);
		e_we    = load_ok && cmd_ch.slot_has_event;
		e_waddr = load_idx;
		e_wdata = cmd_ch.event_in;
		e_re    = (state_q == S_SCAN) && pass_done && found_q;
		e_raddr = best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			n_q         <= '0;
			ptr_q       <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (scan_better) begin
				best_q  <= rd_idx_s1;
				found_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.valid && res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (load_ok) begin
						valid_q[load_idx] <= cmd_ch.slot_has_event;
					end
					if (accept && (cmd_ch.cmd == CMD_READ)) begin
						n_q     <= n_next;
						ptr_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pass_done) begin
						ptr_q   <= '0;
						state_q <= found_q ? S_SUB : S_EMIT;
					end
				end
				S_SUB: begin
					if (pass_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						if (found_q) begin
							valid_q[best_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_better) begin
			dmin_q <= d_rdata;
		end
		rd_idx_s1 <= ptr_q[IDX_W-1:0];
		if (out_load) begin
			out_stream_q <= found_q ? STREAM_W'(best_q) : '0;
			out_delta_q  <= found_q ? DELTA_W'(dmin_q) : '0;
			out_event_q  <= found_q ? e_rdata : '0;
			out_eos_q    <= !found_q;
		end
	end

	assign res_ch.valid          = out_valid_q;
	assign res_ch.out_stream     = out_stream_q;
	assign res_ch.out_delta      = out_delta_q;
	assign res_ch.out_event      = out_event_q;
	assign res_ch.end_of_streams = out_eos_q;

	a_sub_skips_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUB) && d_we |-> (d_waddr != best_q))
		else $error("Subtract pass wrote back the selected slot.");

	a_emit_best_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && found_q |-> valid_q[best_q])
		else $error("Selected slot is not valid at emission.");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUB) |-> (CNT_W'(best_q) < n_q))
		else $error("Selected slot lies outside the streams in use.");

	a_read_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ((state_q == S_SCAN) || (state_q == S_SUB)))
		else $error("Delta memory read returned outside a pass.");

	a_emit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_EMIT) |-> ($past(state_q) == S_SUB) || !found_q)
		else $error("Event emitted without a subtract pass.");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the delta-time stream merger with a slot predictor and a result scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import dtsm_pkg::*;

	localparam int unsigned NSLOTS      = 16;
	localparam int unsigned READ_SETTLE = 2 * NSLOTS + 12;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned RANDOM_ITEMS = 1350;

	typedef struct packed {
		cmd_t                cmd;
		logic [STREAM_W-1:0] stream;
		logic                has_event;
		logic [DELTA_W-1:0]  delta;
		logic [EVENT_W-1:0]  payload;
	} merge_cmd_t;

	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [DELTA_W-1:0]  delta;
		logic [EVENT_W-1:0]  payload;
		logic                eos;
	} merged_event_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	dtsm_cmd_if cmd_ch();
	dtsm_res_if res_ch();

	delta_time_stream_merger dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch),
		.res_ch(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	logic                head_valid [NSLOTS];
	logic [DELTA_W-1:0]  head_delta [NSLOTS];
	logic [EVENT_W-1:0]  head_payload [NSLOTS];
	logic [CFG_W-1:0]    streams_cfg;
	merged_event_t       pending_events [$];
	int                  errors;
	int                  rx_hold_req;
	bit                  rx_steady;
	bit                  tx_burst;
	int                  quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit predict_merge(input merge_cmd_t c, output merged_event_t ev);
		int unsigned n;
		int unsigned best;
		int unsigned i;
		bit found;
		logic [DELTA_W-1:0] dmin;
		n = (streams_cfg > NSLOTS) ? NSLOTS : streams_cfg;
		best = 0;
		found = 1'b0;
		ev = '0;
		if (c.cmd == CMD_LOAD) begin
			head_valid[c.stream] = c.has_event;
			if (c.has_event) begin
				head_delta[c.stream] = c.delta;
				head_payload[c.stream] = c.payload;
			end
			return 1'b0;
		end
		for (i = 0; i < n; i++) begin
			if (head_valid[i] && (!found || head_delta[i] < head_delta[best])) begin
				best = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			ev.eos = 1'b1;
			return 1'b1;
		end
		dmin = head_delta[best];
		for (i = 0; i < n; i++) begin
			if (i != best && head_valid[i])
				head_delta[i] = head_delta[i] - dmin;
		end
		ev.stream = STREAM_W'(best);
		ev.delta = dmin;
		ev.payload = head_payload[best];
		head_valid[best] = 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DELTA_W-1:0] rand_delta();
		case ($urandom_range(0, 3))
			0: return DELTA_W'($urandom);
			1: return DELTA_W'($urandom_range(0, 7));
			default: return DELTA_W'($urandom_range(0, 2000));
		endcase
	endfunction

	task automatic send_cmd(input merge_cmd_t c, output bit has_res, output merged_event_t ev);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= c.cmd;
		cmd_ch.stream_index <= c.stream;
		cmd_ch.slot_has_event <= c.has_event;
		cmd_ch.delta_in <= c.delta;
		cmd_ch.event_in <= c.payload;
		do @(posedge clk); while (!cmd_ch.ready);
		has_res = predict_merge(c, ev);
		if (has_res)
			pending_events.push_back(ev);
	endtask

	task automatic load_slot(input int idx, input bit has, input logic [DELTA_W-1:0] d,
		input logic [EVENT_W-1:0] p);
		merge_cmd_t c;
		bit got;
		merged_event_t ev;
		c.cmd = CMD_LOAD;
		c.stream = STREAM_W'(idx);
		c.has_event = has;
		c.delta = d;
		c.payload = p;
		send_cmd(c, got, ev);
	endtask

	task automatic read_next(output merged_event_t ev);
		merge_cmd_t c;
		bit got;
		c.cmd = CMD_READ;
		c.stream = STREAM_W'($urandom);
		c.has_event = 1'($urandom);
		c.delta = DELTA_W'($urandom);
		c.payload = EVENT_W'($urandom);
		send_cmd(c, got, ev);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (READ_SETTLE) @(posedge clk);
	endtask

	task automatic set_streams(input int unsigned v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		streams_cfg = CFG_W'(v);
	endtask

	task automatic test_directed_merge();
		merged_event_t ev;
		read_next(ev);
		load_slot(0, 1'b1, '1, '1);
		load_slot(15, 1'b1, '0, '0);
		load_slot(7, 1'b1, '0, 24'hA5A5A5);
		repeat (4) read_next(ev);
		load_slot(3, 1'b1, 28'd100, 24'h123456);
		load_slot(3, 1'b0, 28'd5, 24'h654321);
		read_next(ev);
		load_slot(4, 1'b1, 28'd50, 24'h904030);
		load_slot(9, 1'b1, 28'd50, 24'h807F00);
		load_slot(2, 1'b1, 28'd80, 24'hC01234);
		repeat (4) read_next(ev);
	endtask

	task automatic test_stream_count_limits();
		merged_event_t ev;
		set_streams(1);
		load_slot(5, 1'b1, 28'd10, 24'h0F0F0F);
		load_slot(0, 1'b1, 28'd20, 24'hF0F0F0);
		repeat (2) read_next(ev);
		set_streams(0);
		load_slot(0, 1'b1, 28'd1, 24'h111111);
		read_next(ev);
		set_streams(31);
		load_slot(15, 1'b1, 28'd3, 24'h3C3C3C);
		repeat (3) read_next(ev);
		set_streams(17);
		load_slot(2, 1'b1, 28'd1, 24'h222222);
		repeat (3) read_next(ev);
		set_streams(16);
	endtask

	task automatic test_output_backpressure();
		merged_event_t ev;
		int i;
		for (i = 0; i < NSLOTS; i++)
			load_slot(i, 1'b1, rand_delta(), EVENT_W'($urandom));
		tx_burst = 1'b1;
		rx_hold_req = 400;
		repeat (12) read_next(ev);
		tx_burst = 1'b0;
		wait_idle();
	endtask

	task automatic test_sender_pause();
		merged_event_t ev;
		int i;
		for (i = 0; i < 6; i++)
			load_slot(i, 1'b1, rand_delta(), EVENT_W'($urandom));
		repeat (3) read_next(ev);
		cmd_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) read_next(ev);
	endtask

	task automatic test_random_merge();
		merged_event_t ev;
		int sent;
		int r;
		int i;
		int phase_len;
		int unsigned cfg_val;
		int unsigned used;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				cfg_val = 1;
			else if (r < 20)
				cfg_val = 16;
			else if (r < 25)
				cfg_val = $urandom_range(17, 31);
			else
				cfg_val = $urandom_range(1, 16);
			set_streams(cfg_val);
			used = (cfg_val > NSLOTS) ? NSLOTS : cfg_val;
			tx_burst = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			for (i = 0; i < used; i++) begin
				if ($urandom_range(0, 4) != 0) begin
					load_slot(i, 1'b1, rand_delta(), EVENT_W'($urandom));
					sent++;
				end
			end
			phase_len = $urandom_range(40, 120);
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					load_slot($urandom_range(0, NSLOTS - 1), 1'($urandom), DELTA_W'($urandom),
						EVENT_W'($urandom));
					sent++;
				end else begin
					read_next(ev);
					sent++;
					if (!ev.eos) begin
						r = $urandom_range(0, 99);
						if (r < 85) begin
							load_slot(ev.stream, 1'b1, rand_delta(), EVENT_W'($urandom));
							sent++;
						end else if (r < 95) begin
							load_slot(ev.stream, 1'b0, DELTA_W'($urandom), EVENT_W'($urandom));
							sent++;
						end
					end else begin
						repeat ($urandom_range(1, used)) begin
							load_slot($urandom_range(0, used - 1), 1'b1, rand_delta(),
								EVENT_W'($urandom));
							sent++;
						end
					end
				end
			end
		end
		tx_burst = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				stall = rx_hold_req;
				rx_hold_req = 0;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 3) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
						: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		merged_event_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected transfer: out_stream %0d end_of_streams %0b",
					res_ch.out_stream, res_ch.end_of_streams);
				errors++;
			end else begin
				want = pending_events.pop_front();
				if (res_ch.out_stream !== want.stream) begin
					$error("out_stream: expected %0d, actual %0d", want.stream,
						res_ch.out_stream);
					errors++;
				end
				if (res_ch.out_delta !== want.delta) begin
					$error("out_delta: expected %0d, actual %0d", want.delta, res_ch.out_delta);
					errors++;
				end
				if (res_ch.out_event !== want.payload) begin
					$error("out_event: expected %06h, actual %06h", want.payload,
						res_ch.out_event);
					errors++;
				end
				if (res_ch.end_of_streams !== want.eos) begin
					$error("end_of_streams: expected %0b, actual %0b", want.eos,
						res_ch.end_of_streams);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
			|| cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_LOAD;
		cmd_ch.stream_index = '0;
		cmd_ch.slot_has_event = 1'b0;
		cmd_ch.delta_in = '0;
		cmd_ch.event_in = '0;
		errors = 0;
		rx_hold_req = 0;
		rx_steady = 1'b0;
		tx_burst = 1'b0;
		quiet_cycles = 0;
		streams_cfg = STREAMS_RESET;
		for (i = 0; i < NSLOTS; i++)
			head_valid[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_merge();
		test_stream_count_limits();
		test_output_backpressure();
		test_sender_pause();
		test_random_merge();
		wait_idle();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
